// File: hdl/prd_pkg.sv
`timescale 1ns / 1ps
package prd_pkg;
	localparam int COORD_BITS = 12;
	localparam int DIFF_W = (COORD_BITS > 12) ? COORD_BITS : 12;
	localparam int DSQ_W = 2 * DIFF_W;
	localparam int A2_W = DSQ_W + 48;
	localparam int S_W = A2_W + 2;
	localparam int Q_W = 33;
	localparam int DIV_STAGES = Q_W;
	localparam int ROOT_W = 17;
	localparam int SQ_STAGES = ROOT_W;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int UNIT_LAT = DIV_STAGES + SQ_STAGES;
	localparam int FRONT_LAT = 5;
	localparam int TOT_LAT = FRONT_LAT + UNIT_LAT;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_PITCH_X,
		REG_PITCH_Y,
		REG_FOCAL
	} cfg_reg_t;
endpackage

// File: hdl/prd_if.sv
`timescale 1ns / 1ps
interface prd_pix_if;
	logic valid;
	logic ready;
	logic [prd_pkg::COORD_BITS-1:0] column;
	logic [prd_pkg::COORD_BITS-1:0] row;
	modport source (output valid, column, row, input ready);
	modport sink (input valid, column, row, output ready);
endinterface

interface prd_ray_if;
	logic valid;
	logic ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic [14:0] dir_z;
	modport source (output valid, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

// File: hdl/prd_unit.sv
`timescale 1ns / 1ps
module prd_unit (
	input  logic                      clk,
	input  logic                      en,
	input  logic [prd_pkg::S_W-1:0]   a2,
	input  logic [prd_pkg::S_W-1:0]   s,
	input  logic                      neg,
	input  logic                      zero,
	output logic [15:0]               q15
);
	localparam int SW = prd_pkg::S_W;
	localparam int QW = prd_pkg::Q_W;
	localparam int ND = prd_pkg::DIV_STAGES;
	localparam int NS = prd_pkg::SQ_STAGES;
	localparam int RW = prd_pkg::ROOT_W;
	localparam int MW = prd_pkg::REM_W;
	localparam int DW = prd_pkg::RAD_W;

	logic [SW-1:0] rem_s  [ND];
	logic [SW-1:0] den_s  [ND];
	logic [QW-1:0] quo_s  [ND];
	logic          dneg_s [ND];
	logic          dzero_s[ND];

	logic [MW-1:0] srem_s [NS];
	logic [RW-1:0] root_s [NS];
	logic [DW-1:0] rad_s  [NS];
	logic          sneg_s [NS];
	logic          szero_s[NS];

	// restoring division: quotient = floor(a2 * 2^32 / s), one bit per stage
	for (genvar k = 0; k < ND; k++) begin : g_div
		logic [SW:0]   r2;
		logic [SW-1:0] den;
		logic [QW-1:0] qin;
		logic          nin;
		logic          zin;
		logic          ge;
		if (k == 0) begin : g_first
			assign r2  = {1'b0, a2};
			assign den = s;
			assign qin = '0;
			assign nin = neg;
			assign zin = zero;
		end else begin : g_next
			assign r2  = {rem_s[k-1], 1'b0};
			assign den = den_s[k-1];
			assign qin = quo_s[k-1];
			assign nin = dneg_s[k-1];
			assign zin = dzero_s[k-1];
		end
		assign ge = (r2 >= {1'b0, den});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]   <= ge ? SW'(r2 - {1'b0, den}) : r2[SW-1:0];
				den_s[k]   <= den;
				quo_s[k]   <= {qin[QW-2:0], ge};
				dneg_s[k]  <= nin;
				dzero_s[k] <= zin;
			end
		end
	end

	// digit-by-digit integer square root, one root bit per stage
	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		logic [MW-1:0] rin;
		logic [RW-1:0] oin;
		logic [DW-1:0] din;
		logic          nin;
		logic          zin;
		logic [MW+1:0] cur;
		logic [MW+1:0] trial;
		logic          ge;
		if (j == 0) begin : g_first
			assign rin = '0;
			assign oin = '0;
			assign din = DW'(quo_s[ND-1]);
			assign nin = dneg_s[ND-1];
			assign zin = dzero_s[ND-1];
		end else begin : g_next
			assign rin = srem_s[j-1];
			assign oin = root_s[j-1];
			assign din = rad_s[j-1];
			assign nin = sneg_s[j-1];
			assign zin = szero_s[j-1];
		end
		assign cur   = {rin, din[DW-1 -: 2]};
		assign trial = (MW+2)'({oin, 2'b01});
		assign ge    = (cur >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				srem_s[j]  <= ge ? MW'(cur - trial) : cur[MW-1:0];
				root_s[j]  <= {oin[RW-2:0], ge};
				rad_s[j]   <= din << 2;
				sneg_s[j]  <= nin;
				szero_s[j] <= zin;
			end
		end
	end

	logic [RW:0]   rnd;
	logic [15:0]   mag;
	logic          big;

	assign rnd = ({1'b0, root_s[NS-1]} + (RW+1)'(1)) >> 1;
	assign big = rnd[15];
	assign mag = rnd[15:0];

	always_comb begin
		if (szero_s[NS-1]) begin
			q15 = '0;
		end else if (sneg_s[NS-1]) begin
			q15 = 16'(17'h10000 - 17'(mag));
		end else if (big) begin
			q15 = 16'h7fff;
		end else begin
			q15 = mag;
		end
	end
endmodule

// File: hdl/pinhole_ray_direction.sv
`timescale 1ns / 1ps
// channel   dir  beat
// pix       in   column, row
// ray       out  dir_x, dir_y, dir_z
// cfg_*     in   register write: cfg_we, cfg_idx, cfg_data
//
// One beat per cycle while the skid register is not full; from pix to ray a beat passes 5 setup stages,
// 33 divider stages and 17 square-root stages per component, and the output register.
// arst_n clears valid bits, the output/skid flags and loads register defaults.
// A stalled ray fills a skid register; pix.ready drops only while it is full,
// and then the whole pipe holds.
module pinhole_ray_direction (
	input  logic                                clk,
	input  logic                                arst_n,
	prd_pix_if.sink                             pix,
	prd_ray_if.source                           ray,
	input  logic                                cfg_we,
	input  logic [prd_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [prd_pkg::CFG_W-1:0]           cfg_data
);
	localparam int DW = prd_pkg::DIFF_W;
	localparam int QW = prd_pkg::DSQ_W;
	localparam int AW = prd_pkg::A2_W;
	localparam int SW = prd_pkg::S_W;
	localparam int TL = prd_pkg::TOT_LAT;

	logic [12:0] scr_w_q;
	logic [12:0] scr_h_q;
	logic [23:0] pitch_x_q;
	logic [23:0] pitch_y_q;
	logic [23:0] focal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q   <= 13'd640;
			scr_h_q   <= 13'd480;
			pitch_x_q <= 24'd65536;
			pitch_y_q <= 24'd65536;
			focal_q   <= 24'd655360;
		end else if (cfg_we) begin
			case (prd_pkg::cfg_reg_t'(cfg_idx))
				prd_pkg::REG_WIDTH:   scr_w_q   <= cfg_data[12:0];
				prd_pkg::REG_HEIGHT:  scr_h_q   <= cfg_data[12:0];
				prd_pkg::REG_PITCH_X: pitch_x_q <= cfg_data;
				prd_pkg::REG_PITCH_Y: pitch_y_q <= cfg_data;
				prd_pkg::REG_FOCAL:   focal_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_s [TL];
	logic ov_q;
	logic sv_q;
	logic take;
	logic tail_v;

	assign en        = ~sv_q;
	assign pix.ready = en;
	assign tail_v    = vld_s[TL-1];
	assign take      = ov_q & ray.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TL; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pix.valid;
			for (int k = 1; k < TL; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 1: offsets from screen center
	logic [DW:0]   cx, hx, ry, hy, ddx, ddy;
	logic          negx, negy;
	assign cx   = (DW+1)'(pix.column);
	assign hx   = (DW+1)'(scr_w_q[12:1]);
	assign ry   = (DW+1)'(pix.row);
	assign hy   = (DW+1)'(scr_h_q[12:1]);
	assign negx = cx < hx;
	assign negy = ry > hy;
	assign ddx  = negx ? hx - cx : cx - hx;
	assign ddy  = negy ? ry - hy : hy - ry;

	logic [DW-1:0] dx_s1, dy_s1;
	logic          nx_s1, ny_s1;
	logic [QW-1:0] dsx_s2, dsy_s2;
	logic [47:0]   psx_s2, psy_s2, zsq_s2;
	logic          nx_s2, ny_s2;
	logic [QW+23:0] plx_s3, phx_s3, ply_s3, phy_s3;
	logic [47:0]   zsq_s3;
	logic          nx_s3, ny_s3;
	logic [AW-1:0] a2x_s4, a2y_s4;
	logic [47:0]   zsq_s4;
	logic          nx_s4, ny_s4;
	logic [SW-1:0] a2x_s5, a2y_s5, a2z_s5, sum_s5;
	logic          nx_s5, ny_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= ddx[DW-1:0];
			dy_s1  <= ddy[DW-1:0];
			nx_s1  <= negx;
			ny_s1  <= negy;

			dsx_s2 <= QW'(dx_s1 * dx_s1);
			dsy_s2 <= QW'(dy_s1 * dy_s1);
			psx_s2 <= 48'(pitch_x_q * pitch_x_q);
			psy_s2 <= 48'(pitch_y_q * pitch_y_q);
			zsq_s2 <= 48'(focal_q * focal_q);
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;

			plx_s3 <= (QW+24)'(dsx_s2 * psx_s2[23:0]);
			phx_s3 <= (QW+24)'(dsx_s2 * psx_s2[47:24]);
			ply_s3 <= (QW+24)'(dsy_s2 * psy_s2[23:0]);
			phy_s3 <= (QW+24)'(dsy_s2 * psy_s2[47:24]);
			zsq_s3 <= zsq_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;

			a2x_s4 <= AW'(plx_s3) + (AW'(phx_s3) << 24);
			a2y_s4 <= AW'(ply_s3) + (AW'(phy_s3) << 24);
			zsq_s4 <= zsq_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;

			a2x_s5 <= SW'(a2x_s4);
			a2y_s5 <= SW'(a2y_s4);
			a2z_s5 <= SW'(zsq_s4);
			sum_s5 <= SW'(a2x_s4) + SW'(a2y_s4) + SW'(zsq_s4);
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
		end
	end

	logic zero_s5;
	assign zero_s5 = (sum_s5 == '0);

	logic [15:0] qx, qy, qz;

	prd_unit u_x (
		.clk  (clk),
		.en   (en),
		.a2   (a2x_s5),
		.s    (sum_s5),
		.neg  (nx_s5),
		.zero (zero_s5),
		.q15  (qx)
	);

	prd_unit u_y (
		.clk  (clk),
		.en   (en),
		.a2   (a2y_s5),
		.s    (sum_s5),
		.neg  (ny_s5),
		.zero (zero_s5),
		.q15  (qy)
	);

	prd_unit u_z (
		.clk  (clk),
		.en   (en),
		.a2   (a2z_s5),
		.s    (sum_s5),
		.neg  (1'b0),
		.zero (zero_s5),
		.q15  (qz)
	);

	logic [15:0] ox_q, oy_q, sx_q, sy_q;
	logic [14:0] oz_q, sz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (!ov_q || take) begin
				ov_q <= 1'b1;
				sv_q <= 1'b0;
			end
		end else if (!ov_q || take) begin
			ov_q <= tail_v;
		end else if (tail_v) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (!ov_q || take) begin
				ox_q <= sx_q;
				oy_q <= sy_q;
				oz_q <= sz_q;
			end
		end else if (!ov_q || take) begin
			ox_q <= qx;
			oy_q <= qy;
			oz_q <= qz[14:0];
		end else begin
			sx_q <= qx;
			sy_q <= qy;
			sz_q <= qz[14:0];
		end
	end

	assign ray.valid = ov_q;
	assign ray.dir_x = ox_q;
	assign ray.dir_y = oy_q;
	assign ray.dir_z = oz_q;

`ifndef SYNTH
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid full while output register empty");
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q && !ray.ready |=> sv_q && $stable(sx_q) && $stable(sz_q))
		else $error("skid beat lost during stall");
	a_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[TL-1]))
		else $error("pipe tail moved while stalled");
`endif
endmodule
